>>> sv/rkc_pkg.sv
// Package for the RGB kernel convolution unit: widths, register codes,
// reset values, control structs and small helper functions.
// Used by every module of the block; depends on nothing.
package rkc_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int KERNEL_SIZE_DEF = 5;
    localparam int MAX_WIDTH_DEF   = 4096;

    // Pixel and coefficient formats.
    localparam int PIX_W     = 8;
    localparam int RGB_W     = 3 * PIX_W;
    localparam int NUM_CH    = 3;
    localparam int COEF_W    = 12;
    localparam int FRAC_BITS = 10;
    localparam int KROW_W    = 60;
    localparam int NUM_KROWS = 5;
    localparam int IMG_W_W   = 13;
    localparam int MIN_WIDTH = 8;
    localparam int PIX_MAX   = 255;

    // Arithmetic widths: an unsigned pixel times a signed coefficient, then
    // up to eight terms per row and up to eight rows.
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + 3;
    localparam int SUM_W  = ROW_W + 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KROW0       = 3'd0,
        CFG_KROW1       = 3'd1,
        CFG_KROW2       = 3'd2,
        CFG_KROW3       = 3'd3,
        CFG_KROW4       = 3'd4,
        CFG_IMAGE_WIDTH = 3'd5
    } cfg_index_t;

    // Reset values: identity kernel for size five, VGA line width.
    localparam logic [KROW_W-1:0]  KROW_RST_ZERO = '0;
    localparam logic [KROW_W-1:0]  KROW2_RST     = 60'd17179869184;
    localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST = 13'd640;

    // Control that travels with one output pixel through the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic row_end;
        logic run_last;
    } emit_ctrl_t;

    // Window cell that feeds kernel tap l for output step m. Cell 0 holds the
    // newest column. The left edge of the image repeats column 0, the right
    // edge repeats the newest column, and a tap one full window back wraps
    // onto the newest column as the ring of columns does.
    function automatic int tap_cell(int ks, int bd, int m, int l, int cmin);
        int raw;
        raw = 2 * bd - m - l;
        if (raw > cmin) begin
            raw = cmin;
        end
        if (raw < 0) begin
            raw = 0;
        end
        if (raw == ks) begin
            raw = 0;
        end
        return raw;
    endfunction

    // Divide by 1024 toward zero and saturate to 0..255.
    function automatic logic [PIX_W-1:0] finish_channel(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        logic [PIX_W-1:0]        r;
        q = s >>> FRAC_BITS;
        if (s < 0) begin
            r = '0;
        end else if (q > SUM_W'(PIX_MAX)) begin
            r = PIX_W'(PIX_MAX);
        end else begin
            r = q[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/rkc_window_cell.sv
// One column cell of the convolution window: holds a vertical stack of
// pixels and passes it to its right-hand neighbor on every shift.
// Depends on rkc_pkg.
module rkc_window_cell #(
    parameter int KERNEL_SIZE = rkc_pkg::KERNEL_SIZE_DEF
) (
    input  logic                                          aclk,
    input  logic                                          shift_en,
    input  logic [KERNEL_SIZE-1:0][rkc_pkg::RGB_W-1:0]    col_in,
    output logic [KERNEL_SIZE-1:0][rkc_pkg::RGB_W-1:0]    col_out
);
    import rkc_pkg::*;

    logic [KERNEL_SIZE-1:0][RGB_W-1:0] col_reg;

    // Take the neighbor's column whenever a new pixel enters the window.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> sv/rkc_mac.sv
// Multiply-accumulate pipeline and output register: selects the window taps,
// forms all products, sums rows, then the kernel, and scales and saturates.
// Depends on rkc_pkg.
module rkc_mac #(
    parameter int KERNEL_SIZE = rkc_pkg::KERNEL_SIZE_DEF,
    localparam int BORDER     = KERNEL_SIZE / 2,
    localparam int MW         = $clog2(BORDER + 1),
    localparam int CMW        = $clog2(KERNEL_SIZE + 1)
) (
    input  logic                                                      aclk,
    input  logic                                                      aresetn,
    input  rkc_pkg::emit_ctrl_t                                       issue,
    input  logic [MW-1:0]                                             step_m,
    input  logic [CMW-1:0]                                            cmin,
    input  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][rkc_pkg::RGB_W-1:0] win_cols,
    input  logic [rkc_pkg::NUM_KROWS-1:0][rkc_pkg::KROW_W-1:0]        krow,
    output logic                                                      advance,
    output logic                                                      m_tvalid,
    input  logic                                                      m_tready,
    output logic [rkc_pkg::RGB_W-1:0]                                 m_tdata, // blue, green, red
    output logic                                                      m_tlast,
    output logic                                                      m_tuser  // run_last
);
    import rkc_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ROW_W-1:0]  rsum_t;

    prod_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][NUM_CH-1:0] prod_next, prod_reg;
    rsum_t [KERNEL_SIZE-1:0][NUM_CH-1:0]                  rsum_next, rsum_reg;
    logic  [RGB_W-1:0]                                    data_next, data_reg;
    emit_ctrl_t                                           c1_reg, c2_reg, c3_reg;

    // The whole pipeline moves whenever the output register can take a beat.
    assign advance = !c3_reg.valid || m_tready;

    // Stage one: pick the window cell of each tap and multiply per channel.
    always_comb begin
        int                       sel;
        logic [RGB_W-1:0]         pix;
        logic signed [PIX_W:0]    px9;
        logic signed [COEF_W-1:0] cf;
        prod_t                    p;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            for (int l = 0; l < KERNEL_SIZE; l++) begin
                sel = tap_cell(KERNEL_SIZE, BORDER, int'(step_m), l, int'(cmin));
                pix = '0;
                for (int i = 0; i < KERNEL_SIZE; i++) begin
                    if (sel == i) begin
                        pix = win_cols[i][k];
                    end
                end
                cf = $signed(krow[k][COEF_W*l +: COEF_W]);
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    px9 = $signed({1'b0, pix[PIX_W*ch +: PIX_W]});
                    p   = PROD_W'(px9) * PROD_W'(cf);
                    prod_next[k][l][ch] = p;
                end
            end
        end
    end

    // Stage two: sum the products of each kernel row.
    always_comb begin
        rsum_t acc;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc = '0;
                for (int l = 0; l < KERNEL_SIZE; l++) begin
                    acc = acc + ROW_W'(prod_reg[k][l][ch]);
                end
                rsum_next[k][ch] = acc;
            end
        end
    end

    // Stage three: sum the rows, then scale and saturate each channel.
    always_comb begin
        logic signed [SUM_W-1:0] tot;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tot = '0;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                tot = tot + SUM_W'(rsum_reg[k][ch]);
            end
            data_next[PIX_W*ch +: PIX_W] = finish_channel(tot);
        end
    end

    // Pipeline control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end else if (advance) begin
            c1_reg <= issue;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            rsum_reg <= rsum_next;
            data_reg <= data_next;
        end
    end

    assign m_tvalid = c3_reg.valid;
    assign m_tdata  = data_reg;
    assign m_tlast  = c3_reg.row_end;
    assign m_tuser  = c3_reg.run_last;

endmodule

>>> sv/rgb_kernel_convolution_unit.sv
// Top level of the RGB kernel convolution unit: configuration registers,
// row and column counters, line store and the chain of window cells.
// Depends on rkc_pkg, rkc_window_cell and rkc_mac.
// Throughput: one pixel per cycle unless the output stalls; the last pixel of a row
// holds the input while the single MAC pipeline drains the row edge.
// Reset (synchronous, active low) clears counters, pipeline valids and config
// to identity kernel and width 640; the line store is not cleared.
module rgb_kernel_convolution_unit #(
    parameter int KERNEL_SIZE = rkc_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = rkc_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rkc_pkg::RGB_W-1:0]        s_tdata,  // blue_in, green_in, red_in
    input  logic                             s_tuser,  // frame_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rkc_pkg::RGB_W-1:0]        m_tdata,  // blue_out, green_out, red_out
    output logic                             m_tlast,  // row_end
    output logic                             m_tuser,  // run_last
    input  logic                             cfg_we,
    input  logic [rkc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rkc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rkc_pkg::*;

    localparam int BORDER  = KERNEL_SIZE / 2;
    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int FW      = $clog2(KERNEL_SIZE);
    localparam int MW      = $clog2(BORDER + 1);
    localparam int CMW     = $clog2(KERNEL_SIZE + 1);
    localparam int STORE_W = (KERNEL_SIZE - 1) * RGB_W;

    // Configuration registers.
    logic [NUM_KROWS-1:0][KROW_W-1:0] krow_reg;
    logic [IMG_W_W-1:0]               img_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            krow_reg[0]   <= KROW_RST_ZERO;
            krow_reg[1]   <= KROW_RST_ZERO;
            krow_reg[2]   <= KROW2_RST;
            krow_reg[3]   <= KROW_RST_ZERO;
            krow_reg[4]   <= KROW_RST_ZERO;
            img_width_reg <= IMG_WIDTH_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_KROW0:       krow_reg[0]   <= cfg_data;
                CFG_KROW1:       krow_reg[1]   <= cfg_data;
                CFG_KROW2:       krow_reg[2]   <= cfg_data;
                CFG_KROW3:       krow_reg[3]   <= cfg_data;
                CFG_KROW4:       krow_reg[4]   <= cfg_data;
                CFG_IMAGE_WIDTH: img_width_reg <= cfg_data[IMG_W_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective line width, clamped to the supported range.
    logic [IMG_W_W:0] iw_ext;
    logic [IMG_W_W:0] iw_clamp;
    logic [WW-1:0]    w_eff;
    logic [AW-1:0]    w_m1;

    always_comb begin
        iw_ext = {1'b0, img_width_reg};
        if (iw_ext < (IMG_W_W+1)'(MIN_WIDTH)) begin
            iw_clamp = (IMG_W_W+1)'(MIN_WIDTH);
        end else if (iw_ext > (IMG_W_W+1)'(MAX_WIDTH)) begin
            iw_clamp = (IMG_W_W+1)'(MAX_WIDTH);
        end else begin
            iw_clamp = iw_ext;
        end
        w_eff = WW'(iw_clamp);
        w_m1  = AW'(w_eff - WW'(1));
    end

    // Counters and pipeline registers.
    logic [AW-1:0]      col_reg, col_next;
    logic [FW-1:0]      fill_reg, fill_next;

    logic               a_valid_reg;
    logic [AW-1:0]      a_col_reg;
    logic [RGB_W-1:0]   a_pix_reg;
    logic               a_has_emit_reg;
    logic [MW-1:0]      a_m_first_reg, a_m_last_reg;
    logic [CMW-1:0]     a_cmin_reg;
    logic               a_last_col_reg;

    logic               b_busy_reg;
    logic [MW-1:0]      b_m_reg, b_m_last_reg;
    logic [CMW-1:0]     b_cmin_reg;
    logic               b_last_col_reg;

    logic [STORE_W-1:0] rd_reg, fwd_data_reg;
    logic               fwd_hit_reg;

    logic               accept, a_to_b, mac_advance, b_done;

    // Column position of the incoming pixel.
    logic [AW-1:0]  c0, c;
    logic [FW-1:0]  f0, f, f_inc;
    logic           wrap, last_col, fill_done, has_emit;
    logic [MW-1:0]  m_first, m_last;
    logic [CMW-1:0] cmin;

    always_comb begin
        c0    = s_tuser ? '0 : col_reg;
        f0    = s_tuser ? '0 : fill_reg;
        wrap  = (AW+1)'(c0) >= (AW+1)'(w_eff);
        f_inc = (f0 == FW'(KERNEL_SIZE - 1)) ? f0 : f0 + FW'(1);
        c     = wrap ? '0 : c0;
        f     = wrap ? f_inc : f0;

        last_col  = (c == w_m1);
        fill_done = (f == FW'(KERNEL_SIZE - 1));
        has_emit  = fill_done && ((c >= AW'(BORDER)) || last_col);
        m_first   = (c >= AW'(BORDER)) ? MW'(0) : MW'(1);
        m_last    = last_col ? MW'(BORDER) : MW'(0);
        cmin      = (c > AW'(KERNEL_SIZE)) ? CMW'(KERNEL_SIZE) : CMW'(c);

        if (last_col) begin
            col_next  = '0;
            fill_next = (f == FW'(KERNEL_SIZE - 1)) ? f : f + FW'(1);
        end else begin
            col_next  = c + AW'(1);
            fill_next = f;
        end
    end

    // Handshake: the window advances once the current emissions are issued.
    assign b_done   = b_busy_reg && mac_advance && (b_m_reg == b_m_last_reg);
    assign a_to_b   = a_valid_reg && (!b_busy_reg || b_done);
    assign s_tready = !a_valid_reg || a_to_b;
    assign accept   = s_tvalid && s_tready;

    // Line store: one word per column holds the stacked rows above.
    logic [STORE_W-1:0] line_mem [MAX_WIDTH];
    logic [STORE_W-1:0] stack, wr_data;

    assign stack   = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign wr_data = {a_pix_reg, stack[STORE_W-1:RGB_W]};

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[c];
        end
        if (a_to_b) begin
            line_mem[a_col_reg] <= wr_data;
        end
    end

    // Forward a write that lands on the address being read in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (accept) begin
            fwd_hit_reg <= a_to_b && (a_col_reg == c);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg <= wr_data;
        end
    end

    // Counters and the read stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            fill_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg  <= col_next;
                fill_reg <= fill_next;
            end
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_to_b) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_col_reg      <= c;
            a_pix_reg      <= s_tdata;
            a_has_emit_reg <= has_emit;
            a_m_first_reg  <= m_first;
            a_m_last_reg   <= m_last;
            a_cmin_reg     <= cmin;
            a_last_col_reg <= last_col;
        end
    end

    // Emission stage: issues one output step per cycle for the window while the MAC pipeline advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_busy_reg <= 1'b0;
            b_m_reg    <= '0;
        end else if (a_to_b) begin
            b_busy_reg <= a_has_emit_reg;
            b_m_reg    <= a_m_first_reg;
        end else if (b_done) begin
            b_busy_reg <= 1'b0;
        end else if (b_busy_reg && mac_advance) begin
            b_m_reg <= b_m_reg + MW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (a_to_b) begin
            b_m_last_reg   <= a_m_last_reg;
            b_cmin_reg     <= a_cmin_reg;
            b_last_col_reg <= a_last_col_reg;
        end
    end

    // Chain of window cells; cell 0 takes the new column.
    logic [KERNEL_SIZE:0][KERNEL_SIZE-1:0][RGB_W-1:0] chain;

    assign chain[0] = {a_pix_reg, stack};

    for (genvar i = 0; i < KERNEL_SIZE; i++) begin : g_cell
        rkc_window_cell #(
            .KERNEL_SIZE (KERNEL_SIZE)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (a_to_b),
            .col_in   (chain[i]),
            .col_out  (chain[i+1])
        );
    end

    // Control of the step being issued.
    emit_ctrl_t issue;

    always_comb begin
        issue.valid    = b_busy_reg;
        issue.row_end  = b_last_col_reg && (b_m_reg == MW'(BORDER));
        issue.run_last = (b_m_reg == b_m_last_reg);
    end

    rkc_mac #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .step_m   (b_m_reg),
        .cmin     (b_cmin_reg),
        .win_cols (chain[KERNEL_SIZE:1]),
        .krow     (krow_reg),
        .advance  (mac_advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // The step counter never runs past the last step of its pixel.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        b_busy_reg |-> (b_m_reg <= b_m_last_reg))
        else $error("emission step beyond last step");

    // A pixel that emits has a nonempty range of steps.
    a_range_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && a_has_emit_reg) |-> (a_m_first_reg <= a_m_last_reg))
        else $error("empty emission range");

    // The end of a row is always the last result of its pixel.
    a_row_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("row end not last of run");
`endif

endmodule

>>> verif/rgb_kernel_convolution_unit_tb.sv
// Self-checking testbench for rgb_kernel_convolution_unit: streams framed pixels,
// predicts the filtered pixels of all three channels and compares every beat.
// Depends on rkc_pkg and the RTL of the unit only.
module rgb_kernel_convolution_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rkc_pkg::*;

    localparam int KSZ       = 5;
    localparam int BORDER    = KSZ / 2;
    localparam int ROWS_HELD = KSZ - 1;
    localparam int MAXW      = 4096;
    localparam int STALL_LIM = 2000;
    localparam int SETTLE    = 12;

    typedef struct {
        logic [RGB_W-1:0] pix;
        logic             frame_start;
    } pixel_beat_t;

    typedef struct {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             row_end;
        logic             run_last;
    } filtered_pix_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [RGB_W-1:0]      s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RGB_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rgb_kernel_convolution_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the configuration and of the filter state.
    logic [KROW_W-1:0]  kern_rows [NUM_KROWS];
    logic [IMG_W_W-1:0] width_reg;
    logic [RGB_W-1:0]   row_buf [ROWS_HELD][MAXW];
    logic [RGB_W-1:0]   win [KSZ][KSZ];
    int unsigned        col_cnt;
    int unsigned        fill_cnt;

    pixel_beat_t   pending_pix[$];
    filtered_pix_t expected_pix[$];
    int            err_cnt = 0;
    int            pix_in = 0;
    int            pix_out = 0;
    int            queued_pix = 0;
    int            stall_cnt = 0;
    int            in_gap = 0;
    int            out_gap = 0;
    bit            no_idle = 1'b0;

    // Mostly short gaps, now and then a long one; none at all in busy stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One filtered output column from the current window.
    function automatic filtered_pix_t filter_column(int unsigned oc, int unsigned w);
        filtered_pix_t res;
        int            acc [3];
        int            sc;
        int            q;
        logic signed [COEF_W-1:0] cf;
        logic [RGB_W-1:0] p;
        acc = '{0, 0, 0};
        for (int k = 0; k < KSZ; k++) begin
            for (int l = 0; l < KSZ; l++) begin
                sc = int'(oc) + l - BORDER;
                if (sc < 0) sc = 0;
                if (sc > int'(w) - 1) sc = int'(w) - 1;
                cf = kern_rows[k][COEF_W*l +: COEF_W];
                p = win[k][sc % KSZ];
                for (int ch = 0; ch < 3; ch++) begin
                    acc[ch] += int'({1'b0, p[PIX_W*ch +: PIX_W]}) * int'(cf);
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            q = acc[ch] / 1024;
            if (q < 0) q = 0;
            if (q > PIX_MAX) q = PIX_MAX;
            acc[ch] = q;
        end
        res.blue = acc[0][PIX_W-1:0];
        res.green = acc[1][PIX_W-1:0];
        res.red = acc[2][PIX_W-1:0];
        res.row_end = (oc == w - 1);
        res.run_last = 1'b0;
        return res;
    endfunction

    // Advance the shadow state by one accepted pixel and queue its outputs.
    task automatic predict_pixel(input logic [RGB_W-1:0] px, input logic fs);
        int unsigned   w;
        int unsigned   c;
        filtered_pix_t outs[$];
        w = width_reg;
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAXW) w = MAXW;
        if (fs) begin
            col_cnt = 0;
            fill_cnt = 0;
        end
        // A width that shrank under the current column closes the row.
        if (col_cnt >= w) begin
            col_cnt = 0;
            if (fill_cnt < ROWS_HELD) fill_cnt++;
        end
        c = col_cnt;
        for (int j = 0; j < ROWS_HELD; j++) win[j][c % KSZ] = row_buf[j][c];
        win[ROWS_HELD][c % KSZ] = px;
        for (int j = 0; j + 1 < ROWS_HELD; j++) row_buf[j][c] = row_buf[j+1][c];
        row_buf[ROWS_HELD-1][c] = px;
        if (fill_cnt >= ROWS_HELD) begin
            if (c >= BORDER) outs.insert(outs.size(), filter_column(c - BORDER, w));
            if (c == w - 1) begin
                for (int unsigned oc = c - BORDER + 1; oc <= c; oc++) begin
                    outs.insert(outs.size(), filter_column(oc, w));
                end
            end
            if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
            foreach (outs[i]) expected_pix.insert(expected_pix.size(), outs[i]);
        end
        if (c == w - 1) begin
            col_cnt = 0;
            if (fill_cnt < ROWS_HELD) fill_cnt++;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= 30) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // Pixel driver: one beat in flight, refilled from the pending queue.
    always @(posedge aclk) begin
        pixel_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata, s_tuser);
                pix_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_pix.size() > 0) begin
                    b = pending_pix.pop_front();
                    s_tdata <= b.pix;
                    s_tuser <= b.frame_start;
                    s_tvalid <= 1'b1;
                    in_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        filtered_pix_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                pix_out++;
                if (expected_pix.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 0);
                end else begin
                    e = expected_pix.pop_front();
                    if (m_tdata[7:0] !== e.blue) report_mismatch("blue", m_tdata[7:0], e.blue);
                    if (m_tdata[15:8] !== e.green)
                        report_mismatch("green", m_tdata[15:8], e.green);
                    if (m_tdata[23:16] !== e.red) report_mismatch("red", m_tdata[23:16], e.red);
                    if (m_tlast !== e.row_end) report_mismatch("row_end", m_tlast, e.row_end);
                    if (m_tuser !== e.run_last) report_mismatch("run_last", m_tuser, e.run_last);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIM) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIM);
            $display("rgb_kernel_convolution_unit_tb: FAIL");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_KROW0: kern_rows[0] = val;
            CFG_KROW1: kern_rows[1] = val;
            CFG_KROW2: kern_rows[2] = val;
            CFG_KROW3: kern_rows[3] = val;
            CFG_KROW4: kern_rows[4] = val;
            CFG_IMAGE_WIDTH: width_reg = val[IMG_W_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_kernel(input logic [KROW_W-1:0] r0, r1, r2, r3, r4);
        cfg_write(CFG_KROW0, r0);
        cfg_write(CFG_KROW1, r1);
        cfg_write(CFG_KROW2, r2);
        cfg_write(CFG_KROW3, r3);
        cfg_write(CFG_KROW4, r4);
    endtask

    function automatic logic [KROW_W-1:0] rand_row();
        return KROW_W'({$urandom, $urandom});
    endfunction

    // Random pixel with a fair share of all-zero and all-one channels.
    function automatic logic [RGB_W-1:0] rand_pix();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return RGB_W'($urandom);
    endfunction

    // Queue n pixels; the first one optionally opens a frame.
    task automatic queue_pixels(input int n, input bit open_frame);
        pixel_beat_t b;
        for (int i = 0; i < n; i++) begin
            b.pix = rand_pix();
            b.frame_start = open_frame && (i == 0);
            pending_pix.insert(pending_pix.size(), b);
        end
        queued_pix += n;
    endtask

    // Hold the sender until every expected beat has come back.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_pix.size() != 0 || s_tvalid || expected_pix.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        int w;
        for (int k = 0; k < NUM_KROWS; k++) kern_rows[k] = '0;
        kern_rows[2] = KROW2_RST;
        width_reg = IMG_WIDTH_RST;
        col_cnt = 0;
        fill_cnt = 0;
        for (int k = 0; k < KSZ; k++)
            for (int l = 0; l < KSZ; l++) win[k][l] = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Identity kernel from reset, width below the minimum.
        cfg_write(CFG_IMAGE_WIDTH, 0);
        queue_pixels(6 * 8, 1'b1);
        wait_idle();

        // All coefficients at minus one step, then rows mixing full positive and full negative scale.
        cfg_write(CFG_IMAGE_WIDTH, 9);
        set_kernel('1, '1, '1, '1, '1);
        queue_pixels(5 * 9, 1'b1);
        wait_idle();
        set_kernel({5{12'h7ff}}, {5{12'h800}}, {5{12'h7ff}}, '0, {5{12'h001}});
        queue_pixels(5 * 9 + 4, 1'b1);
        wait_idle();

        // Width shrunk in the middle of a row.
        set_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
        cfg_write(CFG_IMAGE_WIDTH, 16);
        queue_pixels(5 * 16 + 11, 1'b1);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 8);
        queue_pixels(20, 1'b0);
        wait_idle();

        // Width above the maximum: a short burst that stays in the fill rows.
        no_idle = 1'b1;
        cfg_write(CFG_IMAGE_WIDTH, 13'h1fff);
        queue_pixels(16, 1'b1);
        wait_idle();
        no_idle = 1'b0;

        // Random frames: small widths, random kernels, frames cut short at times.
        while (queued_pix < 330) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) begin
                set_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
            end
            w = $urandom_range(8, 14);
            cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
            queue_pixels(w * $urandom_range(4, 6) + $urandom_range(0, w - 1), 1'b1);
            wait_idle();
        end
        no_idle = 1'b0;
        wait_idle();

        $display("Covered %0d pixels in and %0d filtered pixels out over identity,", pix_in,
                 pix_out);
        $display("saturating and random kernels, width clamps and a mid-row shrink.");
        if (err_cnt == 0) begin
            $display("rgb_kernel_convolution_unit_tb: PASS");
        end else begin
            $display("rgb_kernel_convolution_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
